>>> rtl/bhsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bhsc_pkg;

    localparam int CORNERS = 8;
    localparam int CI_W    = $clog2(CORNERS);
    localparam int BUD_W   = CI_W + 1;
    localparam int V_W     = 32;
    localparam int N_W     = 18;
    localparam int FRAC    = 16;
    localparam int P_W     = N_W + V_W;
    localparam int EX_W    = P_W + 2;
    localparam int D_W     = EX_W - FRAC;
    localparam int M_W     = N_W + D_W;
    localparam int S_W     = M_W - FRAC + 1;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic signed [V_W-1:0] v_x;
        logic signed [V_W-1:0] v_y;
        logic signed [V_W-1:0] v_z;
        logic signed [N_W-1:0] n_x;
        logic signed [N_W-1:0] n_y;
        logic signed [N_W-1:0] n_z;
        logic signed [D_W-1:0] depth;
        logic [CI_W-1:0]       corner;
        logic                  last;
    } t_job;

endpackage

`default_nettype wire

>>> rtl/box_half_space_contact_top.sv
// Channel   | Handshake          | Beat
// ----------+--------------------+--------------------------------------------
// input     | i_valid / o_ready  | box corners, plane normal and offset, budget
// output    | o_valid / i_ready  | contact point, depth, corner index, last
//
// A box passes through the front's accept, product, pair-sum and corner-sum
// steps, then makes one queue push per contact, k being its contact count (0 to 8).
// The back registers each contact in a product stage and an output stage, one
// contact a cycle while the output is not stalled.
// Synchronous active-low reset clears control only; no clearing pass.
// A stalled output fills the queue, then holds the front in its emit state.
`timescale 1ns / 1ps
`default_nettype none

module box_half_space_contact_top
    import bhsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [V_W-1:0] i_box_min_x,
    input  logic signed [V_W-1:0] i_box_min_y,
    input  logic signed [V_W-1:0] i_box_min_z,
    input  logic signed [V_W-1:0] i_box_max_x,
    input  logic signed [V_W-1:0] i_box_max_y,
    input  logic signed [V_W-1:0] i_box_max_z,
    input  logic signed [N_W-1:0] i_normal_x,
    input  logic signed [N_W-1:0] i_normal_y,
    input  logic signed [N_W-1:0] i_normal_z,
    input  logic signed [V_W-1:0] i_plane_offset,
    input  logic [7:0]            i_contact_budget,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [V_W-1:0] o_contact_x,
    output logic signed [V_W-1:0] o_contact_y,
    output logic signed [V_W-1:0] o_contact_z,
    output logic signed [V_W-1:0] o_depth,
    output logic [CI_W-1:0]       o_corner_index,
    output logic                  o_last
);

    logic f_valid;
    logic f_ready;
    t_job f_job;
    logic q_valid;
    logic q_ready;
    t_job q_job;

    bhsc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_box_min_x      (i_box_min_x),
        .i_box_min_y      (i_box_min_y),
        .i_box_min_z      (i_box_min_z),
        .i_box_max_x      (i_box_max_x),
        .i_box_max_y      (i_box_max_y),
        .i_box_max_z      (i_box_max_z),
        .i_normal_x       (i_normal_x),
        .i_normal_y       (i_normal_y),
        .i_normal_z       (i_normal_z),
        .i_plane_offset   (i_plane_offset),
        .i_contact_budget (i_contact_budget),
        .o_job_valid      (f_valid),
        .i_job_ready      (f_ready),
        .o_job            (f_job)
    );

    bhsc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (f_valid),
        .o_push_ready (f_ready),
        .i_job        (f_job),
        .o_pop_valid  (q_valid),
        .i_pop        (q_ready),
        .o_job        (q_job)
    );

    bhsc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (q_valid),
        .o_job_ready    (q_ready),
        .i_job          (q_job),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_contact_x    (o_contact_x),
        .o_contact_y    (o_contact_y),
        .o_contact_z    (o_contact_z),
        .o_depth        (o_depth),
        .o_corner_index (o_corner_index),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

>>> rtl/bhsc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bhsc_front
    import bhsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [V_W-1:0] i_box_min_x,
    input  logic signed [V_W-1:0] i_box_min_y,
    input  logic signed [V_W-1:0] i_box_min_z,
    input  logic signed [V_W-1:0] i_box_max_x,
    input  logic signed [V_W-1:0] i_box_max_y,
    input  logic signed [V_W-1:0] i_box_max_z,
    input  logic signed [N_W-1:0] i_normal_x,
    input  logic signed [N_W-1:0] i_normal_y,
    input  logic signed [N_W-1:0] i_normal_z,
    input  logic signed [V_W-1:0] i_plane_offset,
    input  logic [7:0]            i_contact_budget,
    output logic                  o_job_valid,
    input  logic                  i_job_ready,
    output t_job                  o_job
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_PAIR,
        ST_CORN,
        ST_EMIT
    } t_state;

    t_state                 r_state;
    logic signed [V_W-1:0]  r_lo   [3];
    logic signed [V_W-1:0]  r_hi   [3];
    logic signed [N_W-1:0]  r_n    [3];
    logic signed [V_W-1:0]  r_w;
    logic [BUD_W-1:0]       r_budget;
    logic [BUD_W-1:0]       r_left;
    logic signed [P_W-1:0]  r_plo  [3];
    logic signed [P_W-1:0]  r_phi  [3];
    logic signed [EX_W-1:0] r_xy   [4];
    logic signed [EX_W-1:0] r_zw   [2];
    logic signed [EX_W-1:0] r_ex   [CORNERS];
    logic [CORNERS-1:0]     r_mask;

    logic signed [EX_W-1:0] ex_sum [CORNERS];
    logic [CORNERS-1:0]     hit;
    logic [CI_W-1:0]        sel;
    logic [CORNERS-1:0]     rest;
    logic                   is_last;
    logic [BUD_W-1:0]       n_budget;

    assign n_budget = (i_contact_budget > 8'(CORNERS)) ? BUD_W'(CORNERS)
                                                       : i_contact_budget[BUD_W-1:0];

    always_comb begin
        for (int c = 0; c < CORNERS; c++) begin
            ex_sum[c] = r_xy[c % 4] + r_zw[c / 4];
            hit[c]    = ex_sum[c][EX_W-1] || (ex_sum[c] == '0);
        end
    end

    always_comb begin
        sel = '0;
        for (int c = CORNERS - 1; c >= 0; c--) begin
            if (r_mask[c]) begin
                sel = CI_W'(c);
            end
        end
        rest    = r_mask & ~(CORNERS'(1) << sel);
        is_last = (rest == '0) || (r_left == BUD_W'(1));
    end

    assign o_ready     = (r_state == ST_IDLE);
    assign o_job_valid = (r_state == ST_EMIT);

    always_comb begin
        o_job.v_x    = sel[0] ? r_hi[0] : r_lo[0];
        o_job.v_y    = sel[1] ? r_hi[1] : r_lo[1];
        o_job.v_z    = sel[2] ? r_hi[2] : r_lo[2];
        o_job.n_x    = r_n[0];
        o_job.n_y    = r_n[1];
        o_job.n_z    = r_n[2];
        o_job.depth  = r_ex[sel][EX_W-1:FRAC];
        o_job.corner = sel;
        o_job.last   = is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_lo[0]  <= i_box_min_x;
                        r_lo[1]  <= i_box_min_y;
                        r_lo[2]  <= i_box_min_z;
                        r_hi[0]  <= i_box_max_x;
                        r_hi[1]  <= i_box_max_y;
                        r_hi[2]  <= i_box_max_z;
                        r_n[0]   <= i_normal_x;
                        r_n[1]   <= i_normal_y;
                        r_n[2]   <= i_normal_z;
                        r_w      <= i_plane_offset;
                        r_budget <= n_budget;
                        r_state  <= ST_PROD;
                    end
                end
                ST_PROD: begin
                    for (int a = 0; a < 3; a++) begin
                        r_plo[a] <= P_W'(r_n[a]) * P_W'(r_lo[a]);
                        r_phi[a] <= P_W'(r_n[a]) * P_W'(r_hi[a]);
                    end
                    r_state <= ST_PAIR;
                end
                ST_PAIR: begin
                    for (int k = 0; k < 4; k++) begin
                        r_xy[k] <= EX_W'(k[0] ? r_phi[0] : r_plo[0])
                                 + EX_W'(k[1] ? r_phi[1] : r_plo[1]);
                    end
                    r_zw[0] <= EX_W'(r_plo[2]) + (EX_W'(r_w) <<< FRAC);
                    r_zw[1] <= EX_W'(r_phi[2]) + (EX_W'(r_w) <<< FRAC);
                    r_state <= ST_CORN;
                end
                ST_CORN: begin
                    for (int c = 0; c < CORNERS; c++) begin
                        r_ex[c] <= ex_sum[c];
                    end
                    r_mask <= hit;
                    r_left <= r_budget;
                    r_state <= ((r_budget == '0) || (hit == '0)) ? ST_IDLE : ST_EMIT;
                end
                ST_EMIT: begin
                    if (i_job_ready) begin
                        r_mask <= rest;
                        r_left <= r_left - BUD_W'(1);
                        if (is_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_emit_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> ((r_mask != '0) && (r_left != '0)))
        else $error("emit state without pending contact");

    a_last_ends_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_job_valid && i_job_ready && o_job.last) |=> (r_state == ST_IDLE))
        else $error("box continues after last contact");

endmodule

`default_nettype wire

>>> rtl/bhsc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module bhsc_queue
    import bhsc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_push_ready,
    input  t_job i_job,
    output logic o_pop_valid,
    input  logic i_pop,
    output t_job o_job
);

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_push_ready = (r_count != (Q_AW + 1)'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_job        = r_mem[r_rd];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            r_count <= r_count + (Q_AW + 1)'(do_push) - (Q_AW + 1)'(do_pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (Q_AW + 1)'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + (Q_AW + 1)'(1)))
        else $error("queue count missed a push");

endmodule

`default_nettype wire

>>> rtl/bhsc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module bhsc_back
    import bhsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    output logic                  o_job_ready,
    input  t_job                  i_job,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [V_W-1:0] o_contact_x,
    output logic signed [V_W-1:0] o_contact_y,
    output logic signed [V_W-1:0] o_contact_z,
    output logic signed [V_W-1:0] o_depth,
    output logic [CI_W-1:0]       o_corner_index,
    output logic                  o_last
);

    logic                  r_p_vld;
    logic signed [M_W-1:0] r_pm [3];
    logic signed [V_W-1:0] r_v  [3];
    logic signed [V_W-1:0] r_p_depth;
    logic [CI_W-1:0]       r_p_corner;
    logic                  r_p_last;

    logic                  r_o_vld;
    logic signed [V_W-1:0] r_pt [3];
    logic signed [V_W-1:0] r_o_depth;
    logic [CI_W-1:0]       r_o_corner;
    logic                  r_o_last;

    logic                  adv_out;
    logic                  adv_p;
    logic signed [N_W-1:0] nv [3];
    logic signed [V_W-1:0] vv [3];
    logic signed [S_W-1:0] sum [3];
    logic signed [V_W-1:0] sat [3];

    assign adv_out     = !r_o_vld || i_ready;
    assign adv_p       = !r_p_vld || adv_out;
    assign o_job_ready = adv_p;

    assign nv[0] = i_job.n_x;
    assign nv[1] = i_job.n_y;
    assign nv[2] = i_job.n_z;
    assign vv[0] = i_job.v_x;
    assign vv[1] = i_job.v_y;
    assign vv[2] = i_job.v_z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            sum[a] = S_W'(r_pm[a] >>> FRAC) + S_W'(r_v[a]);
            if (sum[a][S_W-1:V_W-1] == {(S_W - V_W + 1){sum[a][V_W-1]}}) begin
                sat[a] = sum[a][V_W-1:0];
            end else if (sum[a][S_W-1]) begin
                sat[a] = {1'b1, {(V_W - 1){1'b0}}};
            end else begin
                sat[a] = {1'b0, {(V_W - 1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (adv_p) begin
                r_p_vld <= i_job_valid;
                if (i_job_valid) begin
                    for (int a = 0; a < 3; a++) begin
                        r_pm[a] <= M_W'(nv[a]) * M_W'(i_job.depth);
                        r_v[a]  <= vv[a];
                    end
                    r_p_depth  <= i_job.depth[V_W-1:0];
                    r_p_corner <= i_job.corner;
                    r_p_last   <= i_job.last;
                end
            end
            if (adv_out) begin
                r_o_vld <= r_p_vld;
                if (r_p_vld) begin
                    for (int a = 0; a < 3; a++) begin
                        r_pt[a] <= sat[a];
                    end
                    r_o_depth  <= r_p_depth;
                    r_o_corner <= r_p_corner;
                    r_o_last   <= r_p_last;
                end
            end
        end
    end

    assign o_valid        = r_o_vld;
    assign o_contact_x    = r_pt[0];
    assign o_contact_y    = r_pt[1];
    assign o_contact_z    = r_pt[2];
    assign o_depth        = r_o_depth;
    assign o_corner_index = r_o_corner;
    assign o_last         = r_o_last;

endmodule

`default_nettype wire

>>> tb/box_half_space_contact_top_tb.sv
`timescale 1ns / 1ps

module box_half_space_contact_top_tb;
    import bhsc_pkg::*;

    localparam int ONE        = 65536;
    localparam int QMAX       = 32'h7fff_ffff;
    localparam int QMIN       = 32'h8000_0000;
    localparam int NMAX       = 131071;
    localparam int NMIN       = -131072;
    localparam int RAND_BOXES = 345;
    localparam int LIMIT      = 1000000;
    localparam int TAIL       = 40;

    typedef struct {
        logic signed [V_W-1:0] min_x, min_y, min_z;
        logic signed [V_W-1:0] max_x, max_y, max_z;
        logic signed [N_W-1:0] n_x, n_y, n_z;
        logic signed [V_W-1:0] offset;
        logic [7:0]            budget;
    } box_t;

    typedef struct {
        logic signed [V_W-1:0] x, y, z, depth;
        logic [CI_W-1:0]       corner;
        logic                  last;
    } contact_t;

    class contact_scoreboard;
        contact_t due[$];
        int       mismatches;
        int       checked;
        int       boxes;

        function longint clamp32(longint x);
            if (x > longint'(QMAX)) begin
                return longint'(QMAX);
            end
            if (x < longint'(QMIN)) begin
                return longint'(QMIN);
            end
            return x;
        endfunction

        function void note_box(box_t b);
            longint   lo[3], hi[3], nrm[3], v[3];
            longint   s_exact, dep;
            int       limit;
            contact_t c;
            contact_t made[$];
            lo[0] = longint'(b.min_x);
            lo[1] = longint'(b.min_y);
            lo[2] = longint'(b.min_z);
            hi[0] = longint'(b.max_x);
            hi[1] = longint'(b.max_y);
            hi[2] = longint'(b.max_z);
            nrm[0] = longint'(b.n_x);
            nrm[1] = longint'(b.n_y);
            nrm[2] = longint'(b.n_z);
            limit = (b.budget > CORNERS) ? CORNERS : int'(b.budget);
            boxes++;
            for (int k = 0; k < CORNERS && made.size() < limit; k++) begin
                s_exact = longint'(b.offset) * ONE;
                for (int a = 0; a < 3; a++) begin
                    v[a] = ((k >> a) & 1) ? hi[a] : lo[a];
                    s_exact += nrm[a] * v[a];
                end
                if (s_exact > 0) begin
                    continue;
                end
                dep      = s_exact >>> FRAC;
                c.x      = V_W'(clamp32(v[0] + ((nrm[0] * dep) >>> FRAC)));
                c.y      = V_W'(clamp32(v[1] + ((nrm[1] * dep) >>> FRAC)));
                c.z      = V_W'(clamp32(v[2] + ((nrm[2] * dep) >>> FRAC)));
                c.depth  = dep[V_W-1:0];
                c.corner = k[CI_W-1:0];
                c.last   = 1'b0;
                made.push_back(c);
            end
            if (made.size() > 0) begin
                made[made.size()-1].last = 1'b1;
            end
            foreach (made[i]) begin
                due.push_back(made[i]);
            end
        endfunction

        function void check_contact(contact_t got);
            contact_t want;
            if (due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t unexpected contact: x=%h y=%h z=%h d=%h c=%0d l=%0b",
                             $time, got.x, got.y, got.z, got.depth, got.corner, got.last);
                end
                return;
            end
            want = due.pop_front();
            checked++;
            if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                got.depth !== want.depth || got.corner !== want.corner ||
                got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t contact mismatch: exp x=%h y=%h z=%h d=%h c=%0d l=%0b",
                             $time, want.x, want.y, want.z, want.depth, want.corner, want.last);
                    $display("%0t                   got x=%h y=%h z=%h d=%h c=%0d l=%0b",
                             $time, got.x, got.y, got.z, got.depth, got.corner, got.last);
                end
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic signed [V_W-1:0] i_box_min_x = '0;
    logic signed [V_W-1:0] i_box_min_y = '0;
    logic signed [V_W-1:0] i_box_min_z = '0;
    logic signed [V_W-1:0] i_box_max_x = '0;
    logic signed [V_W-1:0] i_box_max_y = '0;
    logic signed [V_W-1:0] i_box_max_z = '0;
    logic signed [N_W-1:0] i_normal_x = '0;
    logic signed [N_W-1:0] i_normal_y = '0;
    logic signed [N_W-1:0] i_normal_z = '0;
    logic signed [V_W-1:0] i_plane_offset = '0;
    logic [7:0]            i_contact_budget = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic signed [V_W-1:0] o_contact_x;
    logic signed [V_W-1:0] o_contact_y;
    logic signed [V_W-1:0] o_contact_z;
    logic signed [V_W-1:0] o_depth;
    logic [CI_W-1:0]       o_corner_index;
    logic                  o_last;

    contact_scoreboard sb = new;
    bit                hold_rx = 1'b0;
    bit                no_idle = 1'b0;
    int                cycles = 0;

    box_half_space_contact_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_box_min_x      (i_box_min_x),
        .i_box_min_y      (i_box_min_y),
        .i_box_min_z      (i_box_min_z),
        .i_box_max_x      (i_box_max_x),
        .i_box_max_y      (i_box_max_y),
        .i_box_max_z      (i_box_max_z),
        .i_normal_x       (i_normal_x),
        .i_normal_y       (i_normal_y),
        .i_normal_z       (i_normal_z),
        .i_plane_offset   (i_plane_offset),
        .i_contact_budget (i_contact_budget),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_contact_x      (o_contact_x),
        .o_contact_y      (o_contact_y),
        .o_contact_z      (o_contact_z),
        .o_depth          (o_depth),
        .o_corner_index   (o_corner_index),
        .o_last           (o_last)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic box_t mk_box(int lx, int ly, int lz, int hx, int hy, int hz,
                                    int nx, int ny, int nz, int w, int bud);
        box_t b;
        b.min_x  = lx;
        b.min_y  = ly;
        b.min_z  = lz;
        b.max_x  = hx;
        b.max_y  = hy;
        b.max_z  = hz;
        b.n_x    = nx[N_W-1:0];
        b.n_y    = ny[N_W-1:0];
        b.n_z    = nz[N_W-1:0];
        b.offset = w;
        b.budget = bud[7:0];
        return b;
    endfunction

    function automatic int pick_coord();
        case ($urandom_range(0, 5))
            0: return QMIN;
            1: return QMAX;
            2: return 0;
            3: return -1;
            4: return ONE;
            default: return int'($urandom());
        endcase
    endfunction

    function automatic int pick_normal();
        case ($urandom_range(0, 5))
            0: return NMIN;
            1: return NMAX;
            2: return -ONE;
            3: return ONE;
            4: return 0;
            default: return int'($urandom());
        endcase
    endfunction

    function automatic int pick_budget();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            return 0;
        end
        if (r < 78) begin
            return $urandom_range(1, 8);
        end
        return $urandom_range(9, 255);
    endfunction

    // plane through the box centre, nudged a little, so that some corners lie below
    function automatic box_t cutting_box();
        int     c[3], h[3], n[3];
        longint dot;
        for (int a = 0; a < 3; a++) begin
            c[a] = int'($urandom_range(0, 4194304)) - 2097152;
            h[a] = $urandom_range(1, 1048576);
            n[a] = int'($urandom_range(0, 131072)) - ONE;
        end
        dot = longint'(n[0]) * c[0] + longint'(n[1]) * c[1] + longint'(n[2]) * c[2];
        return mk_box(c[0] - h[0], c[1] - h[1], c[2] - h[2], c[0] + h[0], c[1] + h[1],
                      c[2] + h[2], n[0], n[1], n[2],
                      int'(-(dot >>> FRAC)) + int'($urandom_range(0, 16 * ONE)) - 8 * ONE,
                      pick_budget());
    endfunction

    function automatic box_t noise_box();
        return mk_box(int'($urandom()), int'($urandom()), int'($urandom()),
                      int'($urandom()), int'($urandom()), int'($urandom()),
                      int'($urandom()), int'($urandom()), int'($urandom()),
                      int'($urandom()), $urandom_range(0, 255));
    endfunction

    function automatic box_t extreme_box();
        return mk_box(pick_coord(), pick_coord(), pick_coord(),
                      pick_coord(), pick_coord(), pick_coord(),
                      pick_normal(), pick_normal(), pick_normal(),
                      pick_coord(), $urandom_range(0, 255));
    endfunction

    task automatic send_box(box_t b);
        @(negedge i_clk);
        i_box_min_x      = b.min_x;
        i_box_min_y      = b.min_y;
        i_box_min_z      = b.min_z;
        i_box_max_x      = b.max_x;
        i_box_max_y      = b.max_y;
        i_box_max_z      = b.max_z;
        i_normal_x       = b.n_x;
        i_normal_y       = b.n_y;
        i_normal_z       = b.n_z;
        i_plane_offset   = b.offset;
        i_contact_budget = b.budget;
        i_valid          = 1'b1;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        sb.note_box(b);
    endtask

    task automatic idle_for(int n);
        if (n > 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        while (cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int rx_wait;
        rx_wait = 0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_wait > 0) begin
                i_ready = 1'b0;
                rx_wait--;
            end else if (hold_rx) begin
                i_ready = 1'b0;
            end else begin
                i_ready = 1'b1;
                rx_wait = pick_gap();
            end
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                sb.check_contact('{x: o_contact_x, y: o_contact_y, z: o_contact_z,
                                   depth: o_depth, corner: o_corner_index, last: o_last});
            end
        end
    end

    // hold the output off long enough for the block to back up into its input
    initial begin
        while (sb.boxes < 80) begin
            @(posedge i_clk);
        end
        hold_rx = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_rx = 1'b0;
    end

    initial begin
        box_t b;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_box(mk_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 0, ONE, 0, 8));
        send_box(mk_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 0, ONE, 0, 0));
        send_box(mk_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 0, ONE, 0, 1));
        send_box(mk_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 0, ONE, 2 * ONE, 8));
        send_box(mk_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 0, ONE, -2 * ONE, 8));
        send_box(mk_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 0, ONE, -2 * ONE, 255));
        send_box(mk_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 0, ONE, -2 * ONE, 9));
        send_box(mk_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 0, ONE, -2 * ONE, 5));
        send_box(mk_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 0, 0, 0, 8));
        send_box(mk_box(ONE, ONE, ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 8));
        send_box(mk_box(QMIN, QMIN, QMIN, QMAX, QMAX, QMAX, NMIN, NMIN, NMIN, QMIN, 8));
        send_box(mk_box(QMIN, QMIN, QMIN, QMAX, QMAX, QMAX, NMAX, NMAX, NMAX, QMAX, 8));
        send_box(mk_box(QMIN, QMIN, QMIN, QMAX, QMAX, QMAX, -ONE, 0, 0, 0, 8));
        send_box(mk_box(QMAX, QMAX, QMAX, QMIN, QMIN, QMIN, ONE, -ONE, NMAX, QMIN, 8));
        send_box(mk_box(0, 0, 0, 2 * ONE, 2 * ONE, 2 * ONE, 37837, 37837, 37837, -ONE, 3));
        send_box(mk_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, ONE, 0, QMIN, 8));
        send_box(mk_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, -ONE, 0, QMAX, 8));
        send_box(mk_box(0, -ONE, -ONE, ONE, ONE, ONE, ONE, 0, 0, 0, 8));
        send_box(mk_box(-3, 5, -7, 11, 13, -17, NMIN, NMAX, -1, -1, 128));
        drain();

        for (int k = 0; k < RAND_BOXES; k++) begin
            no_idle = (k >= 130 && k < 180);
            if (k == 240) begin
                drain();
            end
            case ($urandom_range(0, 19))
                0, 1, 2:  b = noise_box();
                3, 4, 5:  b = extreme_box();
                default:  b = cutting_box();
            endcase
            send_box(b);
            idle_for(pick_gap());
        end
        no_idle = 1'b0;

        drain();
        repeat (TAIL) @(posedge i_clk);
        if (sb.due.size() != 0) begin
            $display("%0d expected contacts never arrived", sb.due.size());
        end
        $display("%0d boxes sent (directed edges, cutting planes, noise), %0d contacts checked",
                 sb.boxes, sb.checked);
        $display("%0d mismatches over %0d cycles, including a long output hold-off",
                 sb.mismatches, cycles);
        if (sb.mismatches == 0 && sb.due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
